// ===== hw/rtl/frstd_pkg.sv =====
// Shared constants for the fragment reassembly and status TLV decoder:
// header marks, payload limits, query ids, TLV tags and result codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package frstd_pkg;

	localparam logic [15:0] MAX_PAYLOAD = 16'd512;

	localparam logic [7:0] HDR_CONT_MASK = 8'h80;
	localparam logic [7:0] HDR_KIND_MASK = 8'h60;
	localparam logic [7:0] HDR_LEN_MASK  = 8'h1F;
	localparam logic [7:0] HDR_KIND_5    = 8'h00;
	localparam logic [7:0] HDR_KIND_13   = 8'h20;
	localparam logic [7:0] HDR_KIND_16   = 8'h40;

	localparam logic [1:0] CH_CMD = 2'd0;
	localparam logic [1:0] CH_SET = 2'd1;

	localparam logic [7:0] ID_RAW_QUERY = 8'h12;
	localparam logic [7:0] ID_STATUS_A  = 8'h13;
	localparam logic [7:0] ID_STATUS_B  = 8'h53;
	localparam logic [7:0] ID_STATUS_C  = 8'h93;

	localparam logic [7:0] TAG_BUSY    = 8'h08;
	localparam logic [7:0] TAG_REC     = 8'h0A;
	localparam logic [7:0] TAG_SECONDS = 8'h0D;
	localparam logic [7:0] TAG_GPS     = 8'h44;
	localparam logic [7:0] TAG_BATTERY = 8'h46;

	localparam logic [7:0] BATTERY_ABSENT = 8'hFF;

	localparam logic [2:0] EV_CMD_ACK = 3'd0;
	localparam logic [2:0] EV_SET_ACK = 3'd1;
	localparam logic [2:0] EV_RAW     = 3'd2;
	localparam logic [2:0] EV_STATUS  = 3'd3;
	localparam logic [2:0] EV_CLEARED = 3'd4;

	typedef struct packed {
		logic        have_rec;
		logic        have_busy;
		logic        have_gps;
		logic        have_secs;
		logic        rec;
		logic        busy;
		logic        gps;
		logic [7:0]  battery;
		logic [31:0] secs;
	} pend_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fragment_reassembly_status_tlv_decoder.sv =====
// Fragment reassembly and status TLV decoder, top level.
// Depends on frstd_pkg.
//
// Usage: the input channel (in_valid/in_ready) moves one beat per cycle while
// in_ready is high: a notification byte with its channel and start/end marks, or
// a link teardown (kind = 1). The output channel (out_valid/out_ready) moves one
// result beat: command ack, settings ack, raw reply, status update or cleared,
// each with the merged status as it stands after that beat.
// Path: an accepted beat waits in the input register and its result, if any,
// enters the result register once that register is empty or out_ready is high.
// Throughput: one beat per cycle while the receiver takes results; the parse
// state is updated by a single pass of logic between the input register and
// the result register.
// Stall: while a result waits in the result register and out_ready is low,
// the input register holds and in_ready drops once it is full; no beat is
// lost or reordered.
// Reset: arst_n clears the packet in flight, the merged status (flags,
// battery and seconds to 0) and sets the last settings ack to 0xFF/0xFF.
`timescale 1ns / 1ps
`default_nettype none

module fragment_reassembly_status_tlv_decoder
	import frstd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [1:0]  channel,
	input  wire logic [7:0]  data_byte,
	input  wire logic        notify_start,
	input  wire logic        notify_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       event_res,
	output logic [7:0]       reply_id,
	output logic [7:0]       reply_status,
	output logic [15:0]      payload_length,
	output logic             recording,
	output logic             busy_res,
	output logic             gps_lock,
	output logic [7:0]       battery_pct,
	output logic [31:0]      rec_seconds
);

	localparam logic [1:0] HDR_NONE   = 2'd0;
	localparam logic [1:0] HDR_LOW13  = 2'd1;
	localparam logic [1:0] HDR_HIGH16 = 2'd2;
	localparam logic [1:0] HDR_LOW16  = 2'd3;

	localparam logic [1:0] TLV_TAG   = 2'd0;
	localparam logic [1:0] TLV_SIZE  = 2'd1;
	localparam logic [1:0] TLV_VALUE = 2'd2;

	// input register
	logic        valid_s1;
	logic        kind_s1;
	logic [1:0]  channel_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        end_s1;

	// parse state
	logic        active_q, skip_q;
	logic [1:0]  chan_q, hphase_q, tphase_q;
	logic [15:0] expected_q, recv_q;
	logic [7:0]  head_id_q, head_status_q;
	logic [7:0]  tag_q, size_q, index_q;
	logic [31:0] value_q;
	pend_t       pend_q;
	logic [7:0]  last_id_q, last_status_q;
	logic [2:0]  flags_q;
	logic [7:0]  battery_q;
	logic [31:0] seconds_q;

	logic        active_n, skip_n;
	logic [1:0]  chan_n, hphase_n, tphase_n;
	logic [15:0] expected_n, recv_n;
	logic [7:0]  head_id_n, head_status_n;
	logic [7:0]  tag_n, size_n, index_n;
	logic [31:0] value_n;
	pend_t       pend_n;
	logic [7:0]  last_id_n, last_status_n;
	logic [2:0]  flags_n;
	logic [7:0]  battery_n;
	logic [31:0] seconds_n;

	logic        stop;
	logic        fire;
	logic [2:0]  res_ev;
	logic [7:0]  res_id, res_status;
	logic [15:0] res_len;

	// result register
	logic        out_valid_q;
	logic [2:0]  ev_q;
	logic [7:0]  id_q, status_q, bat_out_q;
	logic [15:0] len_q;
	logic [2:0]  flags_out_q;
	logic [31:0] secs_out_q;

	logic adv, go;

	assign adv      = !out_valid_q || out_ready;
	assign go       = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1    <= kind;
			channel_s1 <= channel;
			byte_s1    <= data_byte;
			start_s1   <= notify_start;
			end_s1     <= notify_end;
		end
	end

	always_comb begin
		active_n      = active_q;
		skip_n        = skip_q;
		chan_n        = chan_q;
		hphase_n      = hphase_q;
		tphase_n      = tphase_q;
		expected_n    = expected_q;
		recv_n        = recv_q;
		head_id_n     = head_id_q;
		head_status_n = head_status_q;
		tag_n         = tag_q;
		size_n        = size_q;
		index_n       = index_q;
		value_n       = value_q;
		pend_n        = pend_q;
		last_id_n     = last_id_q;
		last_status_n = last_status_q;
		flags_n       = flags_q;
		battery_n     = battery_q;
		seconds_n     = seconds_q;
		stop          = 1'b0;
		fire          = 1'b0;
		res_ev        = EV_CMD_ACK;
		res_id        = 8'd0;
		res_status    = 8'd0;
		res_len       = 16'd0;

		if (go && kind_s1) begin
			active_n  = 1'b0;
			recv_n    = 16'd0;
			hphase_n  = HDR_NONE;
			skip_n    = 1'b1;
			flags_n   = {flags_q[2], 2'b00};
			seconds_n = 32'd0;
			fire      = 1'b1;
			res_ev    = EV_CLEARED;
		end else if (go) begin
			if (start_s1) begin
				skip_n   = 1'b0;
				hphase_n = HDR_NONE;
				if ((byte_s1 & HDR_CONT_MASK) != 8'd0) begin
					if (!active_q || chan_q != channel_s1) begin
						skip_n = 1'b1;
					end
				end else begin
					active_n      = 1'b1;
					chan_n        = channel_s1;
					recv_n        = 16'd0;
					expected_n    = 16'd0;
					head_id_n     = 8'd0;
					head_status_n = 8'd0;
					tphase_n      = TLV_TAG;
					tag_n         = 8'd0;
					size_n        = 8'd0;
					index_n       = 8'd0;
					value_n       = 32'd0;
					pend_n        = '0;
					pend_n.battery = BATTERY_ABSENT;
					case (byte_s1 & HDR_KIND_MASK)
						HDR_KIND_5: begin
							expected_n = {11'd0, byte_s1[4:0]};
						end
						HDR_KIND_13: begin
							expected_n = {3'd0, byte_s1[4:0], 8'd0};
							hphase_n   = HDR_LOW13;
						end
						HDR_KIND_16: begin
							hphase_n = HDR_HIGH16;
						end
						default: begin
							active_n = 1'b0;
							skip_n   = 1'b1;
						end
					endcase
				end
			end else if (skip_q) begin
				stop = 1'b1;
			end else if (hphase_q == HDR_LOW13 || hphase_q == HDR_LOW16) begin
				expected_n = expected_q | {8'd0, byte_s1};
				hphase_n   = HDR_NONE;
				if (expected_n > MAX_PAYLOAD) begin
					active_n = 1'b0;
					skip_n   = 1'b1;
				end
			end else if (hphase_q == HDR_HIGH16) begin
				expected_n = {byte_s1, 8'd0};
				hphase_n   = HDR_LOW16;
			end else if (active_q && recv_q < expected_q) begin
				recv_n = 16'(recv_q + 16'd1);
				if (recv_q == 16'd0) begin
					head_id_n = byte_s1;
				end else if (recv_q == 16'd1) begin
					head_status_n = byte_s1;
				end else begin
					case (tphase_q)
						TLV_TAG: begin
							tag_n    = byte_s1;
							tphase_n = TLV_SIZE;
						end
						TLV_SIZE: begin
							size_n   = byte_s1;
							index_n  = 8'd0;
							value_n  = 32'd0;
							tphase_n = (byte_s1 == 8'd0) ? TLV_TAG : TLV_VALUE;
						end
						default: begin
							if (tag_q == TAG_SECONDS) begin
								if (index_q < 8'd4) value_n = {value_q[23:0], byte_s1};
							end else if (index_q == 8'd0) begin
								value_n = {24'd0, byte_s1};
							end
							index_n = 8'(index_q + 8'd1);
							if (index_n >= size_q) begin
								tphase_n = TLV_TAG;
								case (tag_q)
									TAG_REC: begin
										pend_n.rec      = value_n != 32'd0;
										pend_n.have_rec = 1'b1;
									end
									TAG_BUSY: begin
										pend_n.busy      = value_n != 32'd0;
										pend_n.have_busy = 1'b1;
									end
									TAG_GPS: begin
										pend_n.gps      = value_n != 32'd0;
										pend_n.have_gps = 1'b1;
									end
									TAG_BATTERY: begin
										pend_n.battery = value_n[7:0];
									end
									TAG_SECONDS: begin
										if (size_q <= 8'd4) begin
											pend_n.secs      = value_n;
											pend_n.have_secs = 1'b1;
										end
									end
									default: begin
									end
								endcase
							end
						end
					endcase
				end
			end

			if (!stop && !skip_n && end_s1) begin
				skip_n = 1'b1;
				if (hphase_n != HDR_NONE) begin
					hphase_n = HDR_NONE;
					active_n = 1'b0;
				end else if (active_n && recv_n >= expected_n) begin
					active_n   = 1'b0;
					recv_n     = 16'd0;
					res_id     = head_id_n;
					res_status = head_status_n;
					res_len    = expected_n;
					if (expected_n >= 16'd2) begin
						if (chan_n == CH_CMD) begin
							fire   = 1'b1;
							res_ev = EV_CMD_ACK;
						end else if (chan_n == CH_SET) begin
							if (!(head_id_n == last_id_q && head_status_n == last_status_q)) begin
								last_id_n     = head_id_n;
								last_status_n = head_status_n;
								fire          = 1'b1;
								res_ev        = EV_SET_ACK;
							end
						end else if (head_id_n == ID_RAW_QUERY) begin
							fire   = head_status_n == 8'd0;
							res_ev = EV_RAW;
						end else if (!(head_id_n inside {ID_STATUS_A, ID_STATUS_B,
								ID_STATUS_C})) begin
							fire   = 1'b1;
							res_ev = EV_RAW;
						end else if (head_status_n == 8'd0) begin
							if (pend_n.have_rec) flags_n[0] = pend_n.rec;
							if (pend_n.have_busy) flags_n[1] = pend_n.busy;
							if (pend_n.have_gps) flags_n[2] = pend_n.gps;
							if (pend_n.battery != BATTERY_ABSENT) battery_n = pend_n.battery;
							if (pend_n.have_secs) seconds_n = pend_n.secs;
							fire   = 1'b1;
							res_ev = EV_STATUS;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			skip_q        <= 1'b0;
			chan_q        <= 2'd0;
			hphase_q      <= HDR_NONE;
			tphase_q      <= TLV_TAG;
			expected_q    <= 16'd0;
			recv_q        <= 16'd0;
			head_id_q     <= 8'd0;
			head_status_q <= 8'd0;
			tag_q         <= 8'd0;
			size_q        <= 8'd0;
			index_q       <= 8'd0;
			value_q       <= 32'd0;
			pend_q        <= '{battery: BATTERY_ABSENT, default: '0};
			last_id_q     <= 8'hFF;
			last_status_q <= 8'hFF;
			flags_q       <= 3'd0;
			battery_q     <= 8'd0;
			seconds_q     <= 32'd0;
		end else begin
			active_q      <= active_n;
			skip_q        <= skip_n;
			chan_q        <= chan_n;
			hphase_q      <= hphase_n;
			tphase_q      <= tphase_n;
			expected_q    <= expected_n;
			recv_q        <= recv_n;
			head_id_q     <= head_id_n;
			head_status_q <= head_status_n;
			tag_q         <= tag_n;
			size_q        <= size_n;
			index_q       <= index_n;
			value_q       <= value_n;
			pend_q        <= pend_n;
			last_id_q     <= last_id_n;
			last_status_q <= last_status_n;
			flags_q       <= flags_n;
			battery_q     <= battery_n;
			seconds_q     <= seconds_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= fire;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && fire) begin
			ev_q        <= res_ev;
			id_q        <= res_id;
			status_q    <= res_status;
			len_q       <= res_len;
			flags_out_q <= flags_n;
			bat_out_q   <= battery_n;
			secs_out_q  <= seconds_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_res      = ev_q;
	assign reply_id       = id_q;
	assign reply_status   = status_q;
	assign payload_length = len_q;
	assign recording      = flags_out_q[0];
	assign busy_res       = flags_out_q[1];
	assign gps_lock       = flags_out_q[2];
	assign battery_pct    = bat_out_q;
	assign rec_seconds    = secs_out_q;

`ifndef NO_ASSERTIONS
	a_cleared_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_CLEARED |->
			reply_id == 8'd0 && payload_length == 16'd0 && !recording && !busy_res
			&& rec_seconds == 32'd0)
		else $error("cleared beat carries stale fields");

	a_status_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_STATUS |-> reply_status == 8'd0
			&& payload_length >= 16'd2)
		else $error("status update from a rejected or short packet");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && hphase_q == HDR_NONE |->
			expected_q <= MAX_PAYLOAD && recv_q <= expected_q)
		else $error("packet length out of bounds");

	a_set_ack_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_SET_ACK |->
			last_id_q == reply_id && last_status_q == reply_status)
		else $error("settings ack not tracked");
`endif

endmodule

`default_nettype wire
